@@ design/avs_pkg.sv @@
// package: sequencer states, register indexes and reset values for the velocity smoother
package avs_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DXX,
    ST_DYY,
    ST_DSUM,
    ST_ROOTD,
    ST_FR,
    ST_FMIN,
    ST_BX0,
    ST_BX1,
    ST_BX2,
    ST_BY1,
    ST_BY2,
    ST_QX,
    ST_QY,
    ST_QC,
    ST_HY,
    ST_HSUM,
    ST_ROOTS,
    ST_K,
    ST_KS,
    ST_PX1,
    ST_PX2,
    ST_PY1,
    ST_PY2,
    ST_FIN
  } state_t;

  localparam logic [2:0] REG_MAX_FACTOR   = 3'd0;
  localparam logic [2:0] REG_FACTOR_SLOPE = 3'd1;
  localparam logic [2:0] REG_SPEED_SQ_LIM = 3'd2;
  localparam logic [2:0] REG_INV_FRIC_RL  = 3'd3;
  localparam logic [2:0] REG_INV_FRIC_SIM = 3'd4;
  localparam logic [2:0] REG_USE_SIM      = 3'd5;

  localparam int ROOT_W  = 34;

  localparam logic [15:0] MAX_FACTOR_RST   = 16'd32768;
  localparam logic [23:0] FACTOR_SLOPE_RST = 24'd4096;
  localparam logic [30:0] SPEED_SQ_RST     = 31'h7fff_ffff;
  localparam logic [19:0] INV_FRIC_RST     = 20'd65536;

  localparam logic [9:0]  MM_PER_M = 10'd1000;

endpackage

@@ design/adaptive_velocity_smoother_unit.sv @@
// top level: adaptive velocity smoother with stop-point prediction
//
//  channel  dir  handshake          payload
//  s_*      in   tvalid/tready      tdata velocity and position, tuser ball flag
//  m_*      out  tvalid/tready      tdata smoothed velocity and stop point, tuser stop flag
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// a frame with a ball that follows a frame with a ball runs the full sequence of products on
// the single shared 33x33 multiplier and two 17-step square-root passes
// other frames go straight to the result state; the input is not ready until the result is loaded
// a result waits in the output register while the next request is taken
// rst is synchronous and clears the held state and all control
module adaptive_velocity_smoother_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // meas_vel_x, meas_vel_y, meas_pos_x, meas_pos_y
  input  logic        s_tuser,   // ball_present
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // smooth_vel_x, smooth_vel_y, stop_pos_x, stop_pos_y
  output logic        m_tuser,   // stop_valid
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);

  avs_pkg::state_t state, state_next;

  logic [15:0] max_factor;
  logic [23:0] factor_slope;
  logic [30:0] speed_sq_limit;
  logic [19:0] inv_friction_real;
  logic [19:0] inv_friction_sim;
  logic        use_simulation;

  logic signed [15:0] held_vel_x, held_vel_y, held_pos_x, held_pos_y;
  logic               prior_seen;

  logic signed [15:0] vel_x, vel_y, pos_x, pos_y;
  logic               present;

  logic signed [15:0] fx, fy, sxp, syp;
  logic [15:0]        f;
  logic [29:0]        kk;
  logic signed [34:0] acc;
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;

  logic [avs_pkg::ROOT_W-1:0] sq_rem, sq_root, sq_bit, sq_try;

  logic signed [16:0] dx, dy;
  logic [16:0]        one_minus_f;
  logic signed [34:0] sum;
  logic               in_fire, fin_fire;

  function automatic logic signed [15:0] blend_round(input logic signed [34:0] s);
    logic signed [34:0] q;
    q = (s + 35'sd32768) >>> 16;
    if (q > 35'sd32767) begin
      return 16'sh7fff;
    end else if (q < -35'sd32768) begin
      return 16'sh8000;
    end else begin
      return q[15:0];
    end
  endfunction

  function automatic logic signed [15:0] stop_round(input logic signed [15:0] pos,
                                                     input logic neg,
                                                     input logic [61:0] p);
    logic [62:0]        r;
    logic signed [27:0] off;
    logic signed [28:0] t;
    r = {1'b0, p} + (63'd1 << 35);
    off = neg ? -$signed({1'b0, r[62:36]}) : $signed({1'b0, r[62:36]});
    t = {{13{pos[15]}}, pos} + {off[27], off};
    if (t > 29'sd32767) begin
      return 16'sh7fff;
    end else if (t < -29'sd32768) begin
      return 16'sh8000;
    end else begin
      return t[15:0];
    end
  endfunction

  assign in_fire     = s_tvalid && s_tready;
  assign fin_fire    = (state == avs_pkg::ST_FIN) && (!m_tvalid || m_tready);
  assign dx          = {vel_x[15], vel_x} - {held_vel_x[15], held_vel_x};
  assign dy          = {vel_y[15], vel_y} - {held_vel_y[15], held_vel_y};
  assign one_minus_f = 17'h10000 - {1'b0, f};
  assign sum         = acc + prod[34:0];
  assign sq_try      = sq_root + sq_bit;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      avs_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_next = (s_tuser && prior_seen) ? avs_pkg::ST_DXX : avs_pkg::ST_FIN;
        end
      end
      avs_pkg::ST_DXX:   state_next = avs_pkg::ST_DYY;
      avs_pkg::ST_DYY:   state_next = avs_pkg::ST_DSUM;
      avs_pkg::ST_DSUM:  state_next = avs_pkg::ST_ROOTD;
      avs_pkg::ST_ROOTD: state_next = sq_bit[0] ? avs_pkg::ST_FR : avs_pkg::ST_ROOTD;
      avs_pkg::ST_FR:    state_next = avs_pkg::ST_FMIN;
      avs_pkg::ST_FMIN:  state_next = avs_pkg::ST_BX0;
      avs_pkg::ST_BX0:   state_next = avs_pkg::ST_BX1;
      avs_pkg::ST_BX1:   state_next = avs_pkg::ST_BX2;
      avs_pkg::ST_BX2:   state_next = avs_pkg::ST_BY1;
      avs_pkg::ST_BY1:   state_next = avs_pkg::ST_BY2;
      avs_pkg::ST_BY2:   state_next = avs_pkg::ST_QX;
      avs_pkg::ST_QX:    state_next = avs_pkg::ST_QY;
      avs_pkg::ST_QY:    state_next = avs_pkg::ST_QC;
      avs_pkg::ST_QC:    state_next = avs_pkg::ST_HY;
      avs_pkg::ST_HY:    state_next = avs_pkg::ST_HSUM;
      avs_pkg::ST_HSUM:  state_next = avs_pkg::ST_ROOTS;
      avs_pkg::ST_ROOTS: state_next = sq_bit[0] ? avs_pkg::ST_K : avs_pkg::ST_ROOTS;
      avs_pkg::ST_K:     state_next = avs_pkg::ST_KS;
      avs_pkg::ST_KS:    state_next = avs_pkg::ST_PX1;
      avs_pkg::ST_PX1:   state_next = avs_pkg::ST_PX2;
      avs_pkg::ST_PX2:   state_next = avs_pkg::ST_PY1;
      avs_pkg::ST_PY1:   state_next = avs_pkg::ST_PY2;
      avs_pkg::ST_PY2:   state_next = avs_pkg::ST_FIN;
      avs_pkg::ST_FIN:   state_next = fin_fire ? avs_pkg::ST_IDLE : avs_pkg::ST_FIN;
      default:           state_next = avs_pkg::ST_IDLE;
    endcase
  end

  // handshake and multiplier operand selection
  always_comb begin
    s_tready = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state)
      avs_pkg::ST_IDLE: s_tready = 1'b1;
      avs_pkg::ST_DXX: begin
        mul_a = {{16{dx[16]}}, dx};
        mul_b = {{16{dx[16]}}, dx};
      end
      avs_pkg::ST_DYY: begin
        mul_a = {{16{dy[16]}}, dy};
        mul_b = {{16{dy[16]}}, dy};
      end
      avs_pkg::ST_FR: begin
        mul_a = {9'd0, factor_slope};
        mul_b = {16'd0, sq_root[16:0]};
      end
      avs_pkg::ST_BX0: begin
        mul_a = {{17{held_vel_x[15]}}, held_vel_x};
        mul_b = {16'd0, one_minus_f};
      end
      avs_pkg::ST_BX1: begin
        mul_a = {{17{vel_x[15]}}, vel_x};
        mul_b = {17'd0, f};
      end
      avs_pkg::ST_BX2: begin
        mul_a = {{17{held_vel_y[15]}}, held_vel_y};
        mul_b = {16'd0, one_minus_f};
      end
      avs_pkg::ST_BY1: begin
        mul_a = {{17{vel_y[15]}}, vel_y};
        mul_b = {17'd0, f};
      end
      avs_pkg::ST_QX: begin
        mul_a = {{17{fx[15]}}, fx};
        mul_b = {{17{fx[15]}}, fx};
      end
      avs_pkg::ST_QY: begin
        mul_a = {{17{fy[15]}}, fy};
        mul_b = {{17{fy[15]}}, fy};
      end
      avs_pkg::ST_QC: begin
        mul_a = {{17{held_vel_x[15]}}, held_vel_x};
        mul_b = {{17{held_vel_x[15]}}, held_vel_x};
      end
      avs_pkg::ST_HY: begin
        mul_a = {{17{held_vel_y[15]}}, held_vel_y};
        mul_b = {{17{held_vel_y[15]}}, held_vel_y};
      end
      avs_pkg::ST_K: begin
        mul_a = {13'd0, use_simulation ? inv_friction_sim : inv_friction_real};
        mul_b = {23'd0, avs_pkg::MM_PER_M};
      end
      avs_pkg::ST_KS: begin
        mul_a = held_vel_x[15] ? -{{17{held_vel_x[15]}}, held_vel_x}
                               : {{17{held_vel_x[15]}}, held_vel_x};
        mul_b = {17'd0, sq_root[15:0]};
      end
      avs_pkg::ST_PX1, avs_pkg::ST_PY1: begin
        mul_a = {1'b0, prod[31:0]};
        mul_b = {3'd0, kk};
      end
      avs_pkg::ST_PX2: begin
        mul_a = held_vel_y[15] ? -{{17{held_vel_y[15]}}, held_vel_y}
                               : {{17{held_vel_y[15]}}, held_vel_y};
        mul_b = {17'd0, sq_root[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= avs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_factor        <= avs_pkg::MAX_FACTOR_RST;
      factor_slope      <= avs_pkg::FACTOR_SLOPE_RST;
      speed_sq_limit    <= avs_pkg::SPEED_SQ_RST;
      inv_friction_real <= avs_pkg::INV_FRIC_RST;
      inv_friction_sim  <= avs_pkg::INV_FRIC_RST;
      use_simulation    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avs_pkg::REG_MAX_FACTOR:   max_factor        <= cfg_data[15:0];
        avs_pkg::REG_FACTOR_SLOPE: factor_slope      <= cfg_data[23:0];
        avs_pkg::REG_SPEED_SQ_LIM: speed_sq_limit    <= cfg_data;
        avs_pkg::REG_INV_FRIC_RL:  inv_friction_real <= cfg_data[19:0];
        avs_pkg::REG_INV_FRIC_SIM: inv_friction_sim  <= cfg_data[19:0];
        avs_pkg::REG_USE_SIM:      use_simulation    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // shared multiplier
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      avs_pkg::ST_IDLE: begin
        if (in_fire) begin
          vel_x   <= s_tdata[15:0];
          vel_y   <= s_tdata[31:16];
          pos_x   <= s_tdata[47:32];
          pos_y   <= s_tdata[63:48];
          present <= s_tuser;
          fx      <= '0;
          fy      <= '0;
          sxp     <= '0;
          syp     <= '0;
        end
      end
      avs_pkg::ST_DYY, avs_pkg::ST_BX1, avs_pkg::ST_BY1, avs_pkg::ST_QY,
      avs_pkg::ST_HY: begin
        acc <= prod[34:0];
      end
      avs_pkg::ST_DSUM, avs_pkg::ST_HSUM: begin
        sq_rem  <= sum[avs_pkg::ROOT_W-1:0];
        sq_root <= '0;
        sq_bit  <= {2'b01, {(avs_pkg::ROOT_W-2){1'b0}}};
      end
      avs_pkg::ST_ROOTD, avs_pkg::ST_ROOTS: begin
        if (sq_rem >= sq_try) begin
          sq_rem  <= sq_rem - sq_try;
          sq_root <= (sq_root >> 1) + sq_bit;
        end else begin
          sq_root <= sq_root >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      avs_pkg::ST_FMIN: begin
        f <= (prod[40:16] < {9'd0, max_factor}) ? prod[31:16] : max_factor;
      end
      avs_pkg::ST_BX2: fx <= blend_round(sum);
      avs_pkg::ST_BY2: fy <= blend_round(sum);
      avs_pkg::ST_QC: begin
        if ($unsigned(sum) > {4'd0, speed_sq_limit}) begin
          fx <= vel_x;
          fy <= vel_y;
        end
      end
      avs_pkg::ST_KS: kk <= prod[29:0];
      avs_pkg::ST_PX2: sxp <= stop_round(held_pos_x, held_vel_x[15], prod[61:0]);
      avs_pkg::ST_PY2: syp <= stop_round(held_pos_y, held_vel_y[15], prod[61:0]);
      default: ;
    endcase
  end

  // held state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_vel_x <= '0;
      held_vel_y <= '0;
      held_pos_x <= '0;
      held_pos_y <= '0;
      prior_seen <= 1'b0;
    end else if (fin_fire) begin
      held_vel_x <= fx;
      held_vel_y <= fy;
      held_pos_x <= present ? pos_x : 16'sd0;
      held_pos_y <= present ? pos_y : 16'sd0;
      prior_seen <= present;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      m_tdata <= {syp, sxp, fy, fx};
      m_tuser <= present && prior_seen;
    end
  end

endmodule

@@ design/avs_checker.sv @@
// checker: port-level properties of the velocity smoother, bound to the top level
module avs_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tuser
);

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a request");

  // a result without stop_valid (no ball, or no prior frame with a ball) carries all zeros
  a_zero_without_prior: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == 64'd0))
    else $error("non-zero result without prior frame");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("stalled result changed");

  // reset leaves an empty, ready block
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("block not idle after reset");

  // a result needs an earlier request with a ball for stop_valid
  a_valid_needs_ball: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> ##1 !(m_tvalid && m_tuser && $rose(m_tvalid)))
    else $error("stop_valid after frame without ball");

endmodule

bind adaptive_velocity_smoother_unit avs_checker u_avs_checker (.*);

@@ sim/adaptive_velocity_smoother_unit_tb.sv @@
// testbench: adaptive velocity smoother driven with directed and random frames, checked per field
module adaptive_velocity_smoother_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int CYCLE_LIMIT = 250000;
  localparam int SLACK_CYCLES = 60;

  typedef struct packed {
    logic present;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_x;
  } meas_frame_t;

  typedef struct packed {
    logic stop_valid;
    logic signed [15:0] stop_pos_y;
    logic signed [15:0] stop_pos_x;
    logic signed [15:0] smooth_vel_y;
    logic signed [15:0] smooth_vel_x;
  } smooth_result_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [63:0] s_tdata;   // meas_vel_x, meas_vel_y, meas_pos_x, meas_pos_y
  logic s_tuser;          // ball_present
  logic m_tvalid;
  logic m_tready;
  logic [63:0] m_tdata;   // smooth_vel_x, smooth_vel_y, stop_pos_x, stop_pos_y
  logic m_tuser;          // stop_valid
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  adaptive_velocity_smoother_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // register copies
  logic [15:0] lim_factor = avs_pkg::MAX_FACTOR_RST;
  logic [23:0] slope_gain = avs_pkg::FACTOR_SLOPE_RST;
  logic [30:0] speed_sq_cap = avs_pkg::SPEED_SQ_RST;
  logic [19:0] inv_fric_real = avs_pkg::INV_FRIC_RST;
  logic [19:0] inv_fric_sim = avs_pkg::INV_FRIC_RST;
  logic sim_select = 1'b0;

  // tracking state
  logic signed [15:0] held_vx = '0;
  logic signed [15:0] held_vy = '0;
  logic signed [15:0] held_px = '0;
  logic signed [15:0] held_py = '0;
  logic track_live = 1'b0;

  smooth_result_t pending_estimates[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  int hold_len = 0;
  bit idle_on = 1'b1;

  logic signed [15:0] trk_vx, trk_vy, trk_px, trk_py;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic longint unsigned root64(input longint unsigned n);
    longint unsigned rem, root, bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [15:0] mix_vel(input logic signed [15:0] old_v,
                                                 input logic signed [15:0] new_v,
                                                 input longint weight);
    longint acc;
    acc = longint'(old_v) * (65536 - weight) + longint'(new_v) * weight;
    acc = (acc + 32768) >>> 16;
    return clamp16(acc);
  endfunction

  function automatic logic signed [15:0] stop_coord(input logic signed [15:0] pos,
                                                    input logic signed [15:0] vel,
                                                    input longint unsigned spd,
                                                    input longint unsigned inv);
    longint v, off;
    longint unsigned mag, prod;
    v = vel;
    mag = (v < 0) ? -v : v;
    prod = mag * spd * inv * 64'd1000;
    off = longint'((prod + (64'd1 << 35)) >> 36);
    if (v < 0) off = -off;
    return clamp16(longint'(pos) + off);
  endfunction

  function automatic smooth_result_t estimate_frame(input meas_frame_t fr);
    smooth_result_t res;
    longint dx, dy, sq;
    longint unsigned d, gain, weight, spd, inv;
    logic signed [15:0] fx, fy;
    res = '0;
    if (!fr.present) begin
      held_vx = '0;
      held_vy = '0;
      held_px = '0;
      held_py = '0;
      track_live = 1'b0;
    end else if (!track_live) begin
      held_vx = '0;
      held_vy = '0;
      held_px = fr.pos_x;
      held_py = fr.pos_y;
      track_live = 1'b1;
    end else begin
      dx = longint'(fr.vel_x) - longint'(held_vx);
      dy = longint'(fr.vel_y) - longint'(held_vy);
      d = root64(dx * dx + dy * dy);
      gain = (64'(slope_gain) * d) >> 16;
      weight = (gain < 64'(lim_factor)) ? gain : 64'(lim_factor);
      fx = mix_vel(held_vx, fr.vel_x, longint'(weight));
      fy = mix_vel(held_vy, fr.vel_y, longint'(weight));
      sq = longint'(fx) * fx + longint'(fy) * fy;
      if (sq > longint'(speed_sq_cap)) begin
        fx = fr.vel_x;
        fy = fr.vel_y;
      end
      spd = root64(longint'(held_vx) * held_vx + longint'(held_vy) * held_vy);
      inv = sim_select ? 64'(inv_fric_sim) : 64'(inv_fric_real);
      res.stop_pos_x = stop_coord(held_px, held_vx, spd, inv);
      res.stop_pos_y = stop_coord(held_py, held_vy, spd, inv);
      res.smooth_vel_x = fx;
      res.smooth_vel_y = fy;
      res.stop_valid = 1'b1;
      held_vx = fx;
      held_vy = fy;
      held_px = fr.pos_x;
      held_py = fr.pos_y;
    end
    return res;
  endfunction

  function automatic meas_frame_t make_frame(input logic present, input int vx, input int vy,
                                             input int px, input int py);
    meas_frame_t fr;
    fr.present = present;
    fr.vel_x = 16'(vx);
    fr.vel_y = 16'(vy);
    fr.pos_x = 16'(px);
    fr.pos_y = 16'(py);
    return fr;
  endfunction

  function automatic meas_frame_t noise_frame(input logic present);
    return make_frame(present, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("adaptive_velocity_smoother_unit test failed");
      $finish;
    end
  end

  // result side
  initial begin
    smooth_result_t want, got;
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_len != 0) begin
        m_tready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = idle_on ? $urandom_range(0, 17) : 0;
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
      got = {m_tuser, m_tdata};
      if (pending_estimates.size() == 0) begin
        flag_mismatch("result with no request outstanding");
      end else begin
        want = pending_estimates.pop_front();
        if (got.smooth_vel_x !== want.smooth_vel_x)
          flag_mismatch($sformatf("smooth_vel_x got %0d want %0d",
                                  got.smooth_vel_x, want.smooth_vel_x));
        if (got.smooth_vel_y !== want.smooth_vel_y)
          flag_mismatch($sformatf("smooth_vel_y got %0d want %0d",
                                  got.smooth_vel_y, want.smooth_vel_y));
        if (got.stop_pos_x !== want.stop_pos_x)
          flag_mismatch($sformatf("stop_pos_x got %0d want %0d",
                                  got.stop_pos_x, want.stop_pos_x));
        if (got.stop_pos_y !== want.stop_pos_y)
          flag_mismatch($sformatf("stop_pos_y got %0d want %0d",
                                  got.stop_pos_y, want.stop_pos_y));
        if (got.stop_valid !== want.stop_valid)
          flag_mismatch($sformatf("stop_valid got %0b want %0b",
                                  got.stop_valid, want.stop_valid));
      end
      @(negedge clk);
    end
  end

  task automatic send_frame(input meas_frame_t fr);
    int gap;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap != 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = {fr.pos_y, fr.pos_x, fr.vel_y, fr.vel_x};
    s_tuser = fr.present;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    pending_estimates.push_back(estimate_frame(fr));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic settle_idle();
    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      avs_pkg::REG_MAX_FACTOR:   lim_factor = value[15:0];
      avs_pkg::REG_FACTOR_SLOPE: slope_gain = value[23:0];
      avs_pkg::REG_SPEED_SQ_LIM: speed_sq_cap = value[30:0];
      avs_pkg::REG_INV_FRIC_RL:  inv_fric_real = value[19:0];
      avs_pkg::REG_INV_FRIC_SIM: inv_fric_sim = value[19:0];
      avs_pkg::REG_USE_SIM:      sim_select = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [30:0] pick_value(input logic [30:0] top);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return top;
      2: return 31'($urandom_range(0, 1 << 12));
      default: return 31'($urandom) & top;
    endcase
  endfunction

  task automatic randomise_settings();
    settle_idle();
    write_reg(avs_pkg::REG_MAX_FACTOR, pick_value(31'h0000_ffff));
    write_reg(avs_pkg::REG_FACTOR_SLOPE, pick_value(31'h00ff_ffff));
    write_reg(avs_pkg::REG_SPEED_SQ_LIM, pick_value(31'h7fff_ffff));
    write_reg(avs_pkg::REG_INV_FRIC_RL, pick_value(31'h000f_ffff));
    write_reg(avs_pkg::REG_INV_FRIC_SIM, pick_value(31'h000f_ffff));
    write_reg(avs_pkg::REG_USE_SIM, 31'($urandom));
  endtask

  // reset settings, extremes of every field, ball lost and found again
  task automatic test_directed_extremes();
    send_frame(make_frame(1'b0, -1, -1, -1, -1));
    send_frame(make_frame(1'b1, 0, 0, 32767, -32768));
    send_frame(make_frame(1'b1, 32767, -32768, 0, 0));
    send_frame(make_frame(1'b1, -32768, 32767, -32768, 32767));
    send_frame(make_frame(1'b1, 0, 0, 100, -100));
    send_frame(make_frame(1'b1, 1024, -2048, 500, 500));
    send_frame(make_frame(1'b0, 32767, 32767, 32767, 32767));
    send_frame(make_frame(1'b1, -32768, -32768, -32768, -32768));
    send_frame(make_frame(1'b1, 32767, 32767, 32767, 32767));
    send_frame(make_frame(1'b1, 32767, 32767, 32767, 32767));
  endtask

  // full blend weight, then speed limit forcing the raw velocity through
  task automatic test_cap_and_replace();
    settle_idle();
    write_reg(avs_pkg::REG_MAX_FACTOR, 31'h0000_ffff);
    write_reg(avs_pkg::REG_FACTOR_SLOPE, 31'h00ff_ffff);
    write_reg(avs_pkg::REG_SPEED_SQ_LIM, 31'd1000);
    send_frame(make_frame(1'b1, 0, 0, 10, 10));
    send_frame(make_frame(1'b1, 20, -10, 20, 20));
    send_frame(make_frame(1'b1, 32767, 32767, 30, 30));
    send_frame(make_frame(1'b1, 32767, 32767, 40, 40));
    settle_idle();
    write_reg(avs_pkg::REG_SPEED_SQ_LIM, 31'd0);
    write_reg(avs_pkg::REG_MAX_FACTOR, 31'd0);
    send_frame(make_frame(1'b1, -5, 3, 50, 50));
    send_frame(make_frame(1'b1, -32768, 1, 60, 60));
  endtask

  // friction selection with saturating stop points, spare indexes left alone
  task automatic test_friction_select();
    settle_idle();
    write_reg(avs_pkg::REG_SPEED_SQ_LIM, 31'h7fff_ffff);
    write_reg(avs_pkg::REG_MAX_FACTOR, 31'h0000_ffff);
    write_reg(avs_pkg::REG_INV_FRIC_RL, 31'h000f_ffff);
    write_reg(avs_pkg::REG_INV_FRIC_SIM, 31'd0);
    write_reg(REG_SPARE_A, 31'h7fff_ffff);
    write_reg(REG_SPARE_B, 31'($urandom));
    send_frame(make_frame(1'b1, -32768, 32767, -30000, 30000));
    send_frame(make_frame(1'b1, -32768, 32767, -30000, 30000));
    send_frame(make_frame(1'b1, 300, -300, 0, 0));
    settle_idle();
    write_reg(avs_pkg::REG_USE_SIM, 31'd1);
    send_frame(make_frame(1'b1, 300, -300, 0, 0));
    send_frame(make_frame(1'b1, 32767, 32767, 0, 0));
    settle_idle();
    write_reg(avs_pkg::REG_USE_SIM, 31'd0);
    send_frame(make_frame(1'b1, 32767, 32767, 0, 0));
  endtask

  task automatic random_phase(input int count, input int step);
    int pick, delta;
    trk_vx = 16'($urandom);
    trk_vy = 16'($urandom);
    trk_px = 16'($urandom);
    trk_py = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_frame(noise_frame(1'b0));
      end else if (pick < 13) begin
        send_frame(noise_frame(1'b1));
      end else begin
        delta = int'($urandom_range(0, 2 * step)) - step;
        trk_vx = clamp16(longint'(trk_vx) + delta);
        delta = int'($urandom_range(0, 2 * step)) - step;
        trk_vy = clamp16(longint'(trk_vy) + delta);
        trk_px = clamp16(longint'(trk_px) + (trk_vx >>> 6));
        trk_py = clamp16(longint'(trk_py) + (trk_vy >>> 6));
        send_frame(make_frame(1'b1, trk_vx, trk_vy, trk_px, trk_py));
      end
    end
  endtask

  // receiver holds off while frames keep coming, so the input stalls
  task automatic test_backpressure();
    randomise_settings();
    idle_on = 1'b0;
    hold_len = 300;
    random_phase(14, 512);
    idle_on = 1'b1;
  endtask

  // sender waits for every outstanding result mid-track
  task automatic test_drain_pause();
    random_phase(6, 256);
    settle_idle();
    random_phase(6, 256);
  endtask

  task automatic test_random_tracks();
    int steps[4] = '{64, 512, 4096, 32767};
    for (int phase = 0; phase < 8; phase++) begin
      randomise_settings();
      idle_on = (phase % 3) != 0;
      random_phase(45, steps[$urandom_range(0, 3)]);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = avs_pkg::REG_MAX_FACTOR;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_cap_and_replace();
    test_friction_select();
    test_backpressure();
    test_drain_pause();
    test_random_tracks();

    while (pending_estimates.size() != 0) @(posedge clk);
    repeat (SLACK_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("adaptive_velocity_smoother_unit test passed");
    end else begin
      $display("adaptive_velocity_smoother_unit test failed");
    end
    $finish;
  end

endmodule
